// ----- design/swm_pkg.sv -----
// swm_pkg: widths, window limits and shared types of the running median filter
// used by the stream interfaces, the sorting cell and the top level
`timescale 1ns / 1ps

package swm_pkg;

  localparam int unsigned MaxWindow  = 64;
  localparam int unsigned SampleBits = 32;
  localparam int unsigned AgeBits    = $clog2(MaxWindow);
  localparam int unsigned CountBits  = $clog2(MaxWindow + 1);
  localparam int unsigned CfgBits    = 7;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [AgeBits-1:0]           age_t;
  typedef logic [CountBits-1:0]         count_t;
  typedef logic [CfgBits-1:0]           cfg_t;

  // one slot of the sorted window
  typedef struct packed {
    logic    valid;
    age_t    age;
    sample_t value;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic    accept;
    logic    clear;
    logic    full;
    age_t    old_age;
    sample_t sample;
  } cell_ctrl_t;

endpackage

// ----- design/swm_sample_if.sv -----
// swm_sample_if: valid/ready channel that carries one input sample word
// depends on swm_pkg for the sample width
`timescale 1ns / 1ps

interface swm_sample_if;
  import swm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- design/swm_median_if.sv -----
// swm_median_if: valid/ready channel that carries one median result word
// depends on swm_pkg for the sample width
`timescale 1ns / 1ps

interface swm_median_if;
  import swm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

// ----- design/swm_cell.sv -----
// swm_cell: one slot of the sorted window, removes the oldest entry and inserts
// the new sample together with its neighbors; depends on swm_pkg
`timescale 1ns / 1ps

module swm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swm_pkg::cell_ctrl_t ctrl_i,
  input  swm_pkg::entry_t    right_i,
  input  logic               right_lt_i,
  input  swm_pkg::entry_t    left_i,
  input  logic               left_lt_i,
  input  logic               rm_i,
  output swm_pkg::entry_t    self_o,
  output logic               self_lt_o,
  output swm_pkg::entry_t    shift_o,
  output logic               shift_lt_o,
  output logic               rm_o
);
  import swm_pkg::*;

  logic    valid_q, valid_d;
  age_t    age_q, age_d;
  sample_t value_q, value_d;
  logic    rm_here;
  logic    take_left;
  logic    take_new;

  always_comb begin
    self_o.valid = valid_q;
    self_o.age   = age_q;
    self_o.value = value_q;
    // an empty slot counts as larger than any sample
    self_lt_o    = !valid_q || (ctrl_i.sample < value_q);
    rm_here      = ctrl_i.full && valid_q && (age_q == ctrl_i.old_age);
    rm_o         = rm_i || rm_here;
    // window after the oldest entry has left
    shift_o      = rm_o ? right_i : self_o;
    shift_lt_o   = rm_o ? right_lt_i : self_lt_o;
  end

  always_comb begin
    take_left = left_i.valid && left_lt_i;
    take_new  = !take_left && shift_lt_o && left_i.valid;
    if (take_left) begin
      valid_d = 1'b1;
      age_d   = left_i.age + age_t'(1);
      value_d = left_i.value;
    end else if (take_new) begin
      valid_d = 1'b1;
      age_d   = '0;
      value_d = ctrl_i.sample;
    end else begin
      valid_d = shift_o.valid;
      age_d   = shift_o.age + age_t'(1);
      value_d = shift_o.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else if (ctrl_i.accept) begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && !ctrl_i.clear) begin
      value_q <= value_d;
    end
  end

endmodule

// ----- design/sliding_window_median.sv -----
// sliding_window_median: top level of the running median filter, a row of
// sorting cells plus fill count and output register; depends on swm_pkg,
// swm_sample_if, swm_median_if and swm_cell
//
// usage:
//   sample_i is a valid/ready sink of signed sample words, median_o a
//   valid/ready source of median words. cfg_we_i/cfg_wdata_i write the window
//   length k (0 acts as 1, above 64 acts as 64); a write empties the window.
//   each accepted sample updates all 64 cells in the same cycle: the oldest
//   entry leaves, the new one is placed in order. once k samples are held,
//   every sample yields the lower median, which waits in a pending flag
//   until it moves into the output register driving median_o. throughput is
//   one sample per clock, set by the cell row and the one-word output register.
//   when median_o stalls with a result still waiting to be moved out,
//   sample_i.ready drops until the output register frees up.
//   reset empties the window, sets k to 1 and drops any pending result.
`timescale 1ns / 1ps

module sliding_window_median (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  swm_pkg::cfg_t       cfg_wdata_i,
  swm_sample_if.sink          sample_i,
  swm_median_if.source        median_o
);
  import swm_pkg::*;

  cfg_t       wsize_q;
  count_t     fill_q, fill_d;
  count_t     k_eff;
  age_t       mid;
  logic       full;
  logic       emit;
  logic       accept;
  logic       move;
  logic       res_pend_q, res_pend_d;
  logic       out_valid_q, out_valid_d;
  sample_t    out_q;
  sample_t    med;
  cell_ctrl_t ctrl;

  entry_t self_e  [MaxWindow];
  logic   self_lt [MaxWindow];
  entry_t shift_e [MaxWindow];
  logic   shift_lt[MaxWindow];
  logic   rm      [MaxWindow];

  entry_t left_sentinel;
  entry_t right_sentinel;

  always_comb begin
    if (wsize_q == '0) begin
      k_eff = count_t'(1);
    end else if (wsize_q > cfg_t'(MaxWindow)) begin
      k_eff = count_t'(MaxWindow);
    end else begin
      k_eff = count_t'(wsize_q);
    end
    mid    = age_t'((k_eff - count_t'(1)) >> 1);
    full   = (fill_q == k_eff);
    fill_d = full ? fill_q : fill_q + count_t'(1);
    emit   = (fill_d == k_eff);
  end

  assign move            = res_pend_q && (!out_valid_q || median_o.ready);
  assign sample_i.ready  = !res_pend_q || move;
  assign accept          = sample_i.valid && sample_i.ready;
  assign res_pend_d      = (accept && emit) || (res_pend_q && !move);
  assign out_valid_d     = move ? 1'b1 : (median_o.ready ? 1'b0 : out_valid_q);
  assign median_o.valid  = out_valid_q;
  assign median_o.median = out_q;

  always_comb begin
    ctrl.accept  = accept;
    ctrl.clear   = cfg_we_i;
    ctrl.full    = full;
    ctrl.old_age = age_t'(k_eff - count_t'(1));
    ctrl.sample  = sample_i.sample;
  end

  // cell 0 sees a smallest-possible left neighbor, the last cell an empty right one
  always_comb begin
    left_sentinel.valid  = 1'b1;
    left_sentinel.age    = '0;
    left_sentinel.value  = '0;
    right_sentinel.valid = 1'b0;
    right_sentinel.age   = '0;
    right_sentinel.value = '0;
  end

  for (genvar i = 0; i < MaxWindow; i++) begin : g_cell
    entry_t left_in;
    logic   left_lt_in;
    entry_t right_in;
    logic   right_lt_in;
    logic   rm_in;

    if (i == 0) begin : g_first
      assign left_in    = left_sentinel;
      assign left_lt_in = 1'b0;
      assign rm_in      = 1'b0;
    end else begin : g_mid
      assign left_in    = shift_e[i-1];
      assign left_lt_in = shift_lt[i-1];
      assign rm_in      = rm[i-1];
    end

    if (i == MaxWindow - 1) begin : g_last
      assign right_in    = right_sentinel;
      assign right_lt_in = 1'b1;
    end else begin : g_inner
      assign right_in    = self_e[i+1];
      assign right_lt_in = self_lt[i+1];
    end

    swm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .right_i    (right_in),
      .right_lt_i (right_lt_in),
      .left_i     (left_in),
      .left_lt_i  (left_lt_in),
      .rm_i       (rm_in),
      .self_o     (self_e[i]),
      .self_lt_o  (self_lt[i]),
      .shift_o    (shift_e[i]),
      .shift_lt_o (shift_lt[i]),
      .rm_o       (rm[i])
    );
  end

  // pick the middle cell as an and-or over the row
  always_comb begin
    med = '0;
    for (int i = 0; i < MaxWindow; i++) begin
      if (age_t'(i) == mid) begin
        med = med | self_e[i].value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q     <= cfg_t'(1);
      fill_q      <= '0;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        wsize_q    <= cfg_wdata_i;
        fill_q     <= '0;
        res_pend_q <= 1'b0;
      end else begin
        res_pend_q <= res_pend_d;
        if (accept) begin
          fill_q <= fill_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= med;
    end
  end

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for sliding_window_median, a running lower-median filter
// drives samples and window lengths, predicts medians from a sample history and
// compares them word by word; depends on swm_pkg, swm_sample_if and swm_median_if
`timescale 1ns / 1ps

module tb;
  import swm_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  cfg_t cfg_wdata;

  swm_sample_if sample_if ();
  swm_median_if median_if ();

  sliding_window_median dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .sample_i   (sample_if),
    .median_o   (median_if)
  );

  sample_t sample_backlog[$];
  sample_t expected_medians[$];
  sample_t window_hist[$];   // arrival order, oldest first
  int      win_len = 1;
  int      errors = 0;
  int      cycles = 0;
  bit      send_busy;
  bit      recv_busy;
  int      send_gap;
  int      recv_stall;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sample_if.valid = 1'b0;
    sample_if.sample = '0;
    median_if.ready = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap(bit busy);
    int r;
    if (!busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clip_window(cfg_t v);
    if (v == 0) return 1;
    if (v > MaxWindow) return MaxWindow;
    return int'(v);
  endfunction

  // lower median: element of rank (k-1)/2 in ascending order
  function automatic sample_t window_median();
    int rank;
    int lt;
    int le;
    rank = (win_len - 1) / 2;
    foreach (window_hist[i]) begin
      lt = 0;
      le = 0;
      foreach (window_hist[j]) begin
        if (window_hist[j] < window_hist[i]) lt++;
        if (window_hist[j] <= window_hist[i]) le++;
      end
      if (lt <= rank && rank < le) return window_hist[i];
    end
    return '0;
  endfunction

  function automatic void push_sample(sample_t s);
    if (window_hist.size() == win_len) void'(window_hist.pop_front());
    window_hist.push_back(s);
    if (window_hist.size() == win_len) expected_medians.push_back(window_median());
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
      send_gap <= 0;
    end else if (!sample_if.valid || sample_if.ready) begin
      if (send_gap != 0) begin
        sample_if.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (sample_backlog.size() != 0) begin
        sample_if.valid <= 1'b1;
        sample_if.sample <= sample_backlog.pop_front();
        send_gap <= pick_gap(send_busy);
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : recv_side
    int n;
    if (!rst_ni) begin
      median_if.ready <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall != 0) begin
      median_if.ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      n = pick_gap(recv_busy);
      if (n == 0) begin
        median_if.ready <= 1'b1;
      end else begin
        median_if.ready <= 1'b0;
        recv_stall <= n - 1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    sample_t want;
    if (rst_ni) begin
      if (cfg_we) begin
        win_len = clip_window(cfg_wdata);
        window_hist.delete();
      end
      if (sample_if.valid && sample_if.ready) push_sample(sample_if.sample);
      if (median_if.valid && median_if.ready) begin
        if (expected_medians.size() == 0) begin
          $display("%0t: unexpected median word %0d, none expected", $time,
                   median_if.median);
          errors++;
        end else begin
          want = expected_medians.pop_front();
          if (median_if.median !== want) begin
            $display("%0t: median mismatch, expected %0d, got %0d", $time, want,
                     median_if.median);
            errors++;
          end
        end
      end
    end
  end

  // checked between edges so the driver's updates have settled
  task automatic wait_sent();
    while (sample_backlog.size() != 0 || sample_if.valid) @(negedge clk_i);
  endtask

  // everything sent and every median moved out, then idle slack before returning
  task automatic drain();
    wait_sent();
    while (expected_medians.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(cfg_t v);
    drain();
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    if (r < 4) return sample_t'($signed($urandom_range(0, 6)) - 3);
    return sample_t'($urandom);
  endfunction

  initial begin : stimulus
    cfg_t k_list[$];
    cfg_t k;
    int   total;
    int   n;
    int   ph;
    send_busy = 1'b1;
    recv_busy = 1'b1;
    k_list = '{7'd127, 7'd64, 7'd65, 7'd1, 7'd2, 7'd63, 7'd4, 7'd32};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // window length 1 out of reset: every word is its own median
    sample_backlog = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1, 32'sd1};
    drain();

    // odd window with extremes and runs of equal values
    write_window(7'd3);
    sample_backlog = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sd5, 32'sd5, 32'sd5,
                       -32'sd2, 32'sd5, -32'sd2, 32'sh8000_0000, 32'sh8000_0000};
    drain();

    // zero acts as one
    write_window(7'd0);
    sample_backlog = '{32'sd9, -32'sd9, 32'sh8000_0000};
    drain();

    // even window takes the lower of the middle pair; rewrite clears a partial fill
    write_window(7'd2);
    sample_backlog = '{32'sd1};
    drain();
    write_window(7'd2);
    sample_backlog = '{32'sd1, -32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF};
    drain();

    total = 0;
    ph = 0;
    while (total < 1100) begin
      k = (ph < k_list.size()) ? k_list[ph] : cfg_t'($urandom_range(0, 127));
      write_window(k);
      if (ph == 0) begin
        send_busy = 1'b1;
        recv_busy = 1'b1;
      end else if (ph == 1) begin
        send_busy = 1'b0;
        recv_busy = 1'b0;
      end else begin
        send_busy = $urandom_range(0, 2) != 0;
        recv_busy = $urandom_range(0, 2) != 0;
      end
      n = clip_window(k) + $urandom_range(10, 120);
      for (int i = 0; i < n; i++) begin
        sample_backlog.push_back(rand_sample());
        // sender holds off until every median so far has come out
        if (i == n / 2 && (ph == 0 || $urandom_range(0, 2) == 0)) begin
          wait_sent();
          while (expected_medians.size() != 0) @(posedge clk_i);
        end
      end
      total += n;
      ph++;
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (expected_medians.size() != 0) begin
      $display("%0t: %0d median words never arrived", $time, expected_medians.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
